// ===== rtl/meg_pkg.sv =====
// Shared types and constants of the modem escape guard detector.
`default_nettype none

package meg_pkg;

	localparam int unsigned MODE_W     = 2;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned TIME_W     = 32;
	localparam int unsigned UNITS_W    = 8;
	localparam int unsigned GUARD_MS_W = 13;
	localparam int unsigned COUNT_W    = 2;
	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;

	localparam logic [GUARD_MS_W-1:0] GUARD_MS_PER_UNIT = 13'd20;
	localparam logic [COUNT_W-1:0]    ESC_RUN_LENGTH    = 2'd3;
	localparam logic [BYTE_W-1:0]     ESC_RESET_CHAR    = 8'd43;
	localparam logic [UNITS_W-1:0]    GUARD_RESET_UNITS = 8'd50;

	// Register index, taken from paddr[2].
	localparam logic REG_ESCAPE_CHAR = 1'b0;
	localparam logic REG_GUARD_UNITS = 1'b1;

	typedef enum logic [MODE_W-1:0] {
		MODE_DATA  = 2'd0,
		MODE_TICK  = 2'd1,
		MODE_ENTER = 2'd2
	} mode_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  escape_char;
		logic [UNITS_W-1:0] guard_units;
	} cfg_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [BYTE_W-1:0] data_byte;
		logic [TIME_W-1:0] time_ms;
	} item_t;

	typedef struct packed {
		logic              forward_valid;
		logic [BYTE_W-1:0] forward_byte;
		logic              escape_done;
		logic              in_data_mode;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/meg_if.sv =====
// Handshake channels for input items and result items.
`default_nettype none

interface meg_in_if import meg_pkg::*;;
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [BYTE_W-1:0] data_byte;
	logic [TIME_W-1:0] time_ms;

	modport source (output valid, output mode, output data_byte, output time_ms, input ready);
	modport sink   (input valid, input mode, input data_byte, input time_ms, output ready);
endinterface

interface meg_out_if import meg_pkg::*;;
	logic              valid;
	logic              ready;
	logic              forward_valid;
	logic [BYTE_W-1:0] forward_byte;
	logic              escape_done;
	logic              in_data_mode;

	modport source (output valid, output forward_valid, output forward_byte,
		output escape_done, output in_data_mode, input ready);
	modport sink   (input valid, input forward_valid, input forward_byte,
		input escape_done, input in_data_mode, output ready);
endinterface

`default_nettype wire

// ===== rtl/meg_cfg.sv =====
// APB register block holding the escape character and the guard time.
`default_nettype none

module meg_cfg import meg_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	output cfg_t                       cfg
);

	logic [BYTE_W-1:0]  escape_char_q;
	logic [UNITS_W-1:0] guard_units_q;
	logic               wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_char_q <= ESC_RESET_CHAR;
			guard_units_q <= GUARD_RESET_UNITS;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_ESCAPE_CHAR: escape_char_q <= pwdata[BYTE_W-1:0];
				REG_GUARD_UNITS: guard_units_q <= pwdata[UNITS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_ESCAPE_CHAR: prdata = APB_DATA_W'(escape_char_q);
			REG_GUARD_UNITS: prdata = APB_DATA_W'(guard_units_q);
			default:         prdata = '0;
		endcase
	end

	assign cfg.escape_char = escape_char_q;
	assign cfg.guard_units = guard_units_q;

endmodule

`default_nettype wire

// ===== rtl/meg_engine.sv =====
// Input register, escape tracking state and result register of the detector.
`default_nettype none

module meg_engine import meg_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	meg_in_if.sink     in_ch,
	meg_out_if.source  out_ch
);

	// Input stage
	logic  v_s1;
	item_t item_s1;
	// Result stage
	logic    v_s2;
	result_t res_s2;

	// Tracking state
	logic               online_q;
	logic [COUNT_W-1:0] esc_count_q;
	logic               armed_q;
	logic [TIME_W-1:0]  last_time_q;
	logic [TIME_W-1:0]  third_time_q;

	logic               advance;
	logic               take_in;
	logic [GUARD_MS_W-1:0] guard_ms;
	logic [TIME_W-1:0]  guard_w;
	logic [TIME_W-1:0]  byte_gap;
	logic [TIME_W-1:0]  tick_gap;
	logic               byte_gap_ok;
	logic               tick_gap_ok;

	logic               online_d;
	logic [COUNT_W-1:0] esc_count_d;
	logic               armed_d;
	logic [TIME_W-1:0]  last_time_d;
	logic [TIME_W-1:0]  third_time_d;
	logic [COUNT_W-1:0] cnt_next;
	result_t            res_d;

	// The result stage frees up in the same cycle as its transfer, so an item
	// may move on every cycle while the output side keeps taking.
	assign advance      = v_s1 && (!v_s2 || out_ch.ready);
	assign in_ch.ready  = !v_s1 || advance;
	assign take_in      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take_in) begin
			v_s1 <= 1'b1;
		end else if (advance) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1.mode      <= in_ch.mode;
			item_s1.data_byte <= in_ch.data_byte;
			item_s1.time_ms   <= in_ch.time_ms;
		end
	end

	assign guard_ms    = GUARD_MS_W'(cfg.guard_units) * GUARD_MS_PER_UNIT;
	assign guard_w     = TIME_W'(guard_ms);
	assign byte_gap    = item_s1.time_ms - last_time_q;
	assign tick_gap    = item_s1.time_ms - third_time_q;
	assign byte_gap_ok = byte_gap >= guard_w;
	assign tick_gap_ok = tick_gap >= guard_w;

	// Count of escape characters after this byte, when it is one.
	always_comb begin
		if (esc_count_q == '0) begin
			cnt_next = byte_gap_ok ? COUNT_W'(1) : '0;
		end else if (esc_count_q < ESC_RUN_LENGTH && !byte_gap_ok) begin
			cnt_next = esc_count_q + COUNT_W'(1);
		end else begin
			cnt_next = '0;
		end
	end

	always_comb begin
		online_d     = online_q;
		esc_count_d  = esc_count_q;
		armed_d      = armed_q;
		last_time_d  = last_time_q;
		third_time_d = third_time_q;
		res_d        = '0;

		unique case (mode_t'(item_s1.mode))
			MODE_DATA: begin
				if (online_q) begin
					res_d.forward_valid = 1'b1;
					res_d.forward_byte  = item_s1.data_byte;
					last_time_d         = item_s1.time_ms;
					if (item_s1.data_byte == cfg.escape_char) begin
						esc_count_d = cnt_next;
						// A third escape arms; an armed escape otherwise stays armed.
						if (cnt_next == ESC_RUN_LENGTH) begin
							armed_d      = 1'b1;
							third_time_d = item_s1.time_ms;
						end
					end else begin
						esc_count_d = '0;
						armed_d     = 1'b0;
					end
				end
			end
			MODE_TICK: begin
				if (online_q && armed_q && tick_gap_ok) begin
					armed_d           = 1'b0;
					esc_count_d       = '0;
					online_d          = 1'b0;
					res_d.escape_done = 1'b1;
				end
			end
			MODE_ENTER: begin
				online_d    = 1'b1;
				esc_count_d = '0;
				armed_d     = 1'b0;
				last_time_d = item_s1.time_ms;
			end
			default: ;
		endcase

		res_d.in_data_mode = online_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			online_q     <= 1'b0;
			esc_count_q  <= '0;
			armed_q      <= 1'b0;
			last_time_q  <= '0;
			third_time_q <= '0;
		end else if (advance) begin
			online_q     <= online_d;
			esc_count_q  <= esc_count_d;
			armed_q      <= armed_d;
			last_time_q  <= last_time_d;
			third_time_q <= third_time_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	assign out_ch.valid         = v_s2;
	assign out_ch.forward_valid = res_s2.forward_valid;
	assign out_ch.forward_byte  = res_s2.forward_byte;
	assign out_ch.escape_done   = res_s2.escape_done;
	assign out_ch.in_data_mode  = res_s2.in_data_mode;

	// A completed escape always leaves data mode.
	a_done_offline: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && res_s2.escape_done |-> !res_s2.in_data_mode)
		else $error("escape reported while still in data mode");

	// A byte is never forwarded on the same item that ends an escape.
	a_done_no_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && res_s2.escape_done |-> !res_s2.forward_valid)
		else $error("byte forwarded with escape completion");

	// A full run of escape characters always leaves the escape armed.
	a_run_armed: assert property (@(posedge clk) disable iff (!arst_n)
		esc_count_q == ESC_RUN_LENGTH |-> armed_q)
		else $error("escape run complete but not armed");

	// In command mode no escape tracking is held.
	a_cmd_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!online_q |-> (esc_count_q == '0) && !armed_q)
		else $error("escape state held in command mode");

	// An item that moves on from the input register reaches the result stage at the next edge.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> v_s2)
		else $error("result lost after processing");

endmodule

`default_nettype wire

// ===== rtl/modem_escape_guard_detector.sv =====
// Top level of the modem escape guard detector.
//
// Watches a stream of timestamped items (data byte, poll tick, enter data mode) for the
// guarded three-character escape and gives exactly one result per item. An item is taken
// into an input register, handled by one pass of compare and subtract logic against the
// tracking state, and lands in a result register, so one item is accepted per clock cycle
// while the output side keeps taking. Its result is offered once the item has passed the input
// register and the result register in turn. When the output stalls, one further item is taken
// into the input register and the input then stalls too. The escape character and guard time
// (in units of 20 ms) are set through the APB port at byte addresses 0 and 4; the user must
// write them only while idle, which the block itself does not enforce.
`default_nettype none

module modem_escape_guard_detector import meg_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	meg_in_if.sink                     in_ch,
	meg_out_if.source                  out_ch,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready
);

	cfg_t cfg;

	meg_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	meg_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

endmodule

`default_nettype wire

// ===== tb/modem_escape_guard_detector_tb.sv =====
// Testbench for the modem escape guard detector: random and directed item streams against a predictor.
`timescale 1ns / 100ps

class guard_scoreboard;
	// Copy of the register settings.
	logic [7:0] escape_char;
	logic [7:0] guard_units;

	// Tracking state of the escape detector.
	logic        online;
	logic [1:0]  esc_run;
	logic        esc_armed;
	logic [31:0] prev_byte_ms;
	logic [31:0] third_esc_ms;

	meg_pkg::result_t pending_link_results[$];
	int unsigned mismatches;

	function new();
		escape_char  = meg_pkg::ESC_RESET_CHAR;
		guard_units  = meg_pkg::GUARD_RESET_UNITS;
		online       = 1'b0;
		esc_run      = '0;
		esc_armed    = 1'b0;
		prev_byte_ms = '0;
		third_esc_ms = '0;
		mismatches   = 0;
	endfunction

	function logic [31:0] guard_ms();
		return 32'(guard_units) * 32'd20;
	endfunction

	function void note_item(meg_pkg::item_t it);
		meg_pkg::result_t r;
		logic [31:0] g;
		logic [31:0] gap;
		r = '0;
		g = guard_ms();
		case (it.mode)
			meg_pkg::MODE_DATA: begin
				if (online) begin
					gap = it.time_ms - prev_byte_ms;
					if (it.data_byte == escape_char) begin
						if (esc_run == 2'd0)
							esc_run = (gap >= g) ? 2'd1 : 2'd0;
						else if (esc_run < meg_pkg::ESC_RUN_LENGTH && gap < g)
							esc_run = esc_run + 2'd1;
						else
							esc_run = 2'd0;
						if (esc_run == meg_pkg::ESC_RUN_LENGTH) begin
							esc_armed    = 1'b1;
							third_esc_ms = it.time_ms;
						end
					end else begin
						esc_run   = 2'd0;
						esc_armed = 1'b0;
					end
					prev_byte_ms    = it.time_ms;
					r.forward_valid = 1'b1;
					r.forward_byte  = it.data_byte;
				end
			end
			meg_pkg::MODE_TICK: begin
				if (online && esc_armed && (it.time_ms - third_esc_ms) >= g) begin
					esc_armed     = 1'b0;
					esc_run       = 2'd0;
					online        = 1'b0;
					r.escape_done = 1'b1;
				end
			end
			meg_pkg::MODE_ENTER: begin
				online       = 1'b1;
				esc_run      = 2'd0;
				esc_armed    = 1'b0;
				prev_byte_ms = it.time_ms;
			end
			default: begin
			end
		endcase
		r.in_data_mode = online;
		pending_link_results.push_back(r);
	endfunction

	function void check_result(meg_pkg::result_t got);
		meg_pkg::result_t exp;
		if (pending_link_results.size() == 0) begin
			$display("%0t: unexpected result fv=%0b fb=%02h ed=%0b dm=%0b", $time,
				got.forward_valid, got.forward_byte, got.escape_done, got.in_data_mode);
			mismatches++;
			return;
		end
		exp = pending_link_results.pop_front();
		if (got !== exp) begin
			$display("%0t: result mismatch, expected fv=%0b fb=%02h ed=%0b dm=%0b, got fv=%0b fb=%02h ed=%0b dm=%0b",
				$time, exp.forward_valid, exp.forward_byte, exp.escape_done, exp.in_data_mode,
				got.forward_valid, got.forward_byte, got.escape_done, got.in_data_mode);
			mismatches++;
		end
	endfunction
endclass

module modem_escape_guard_detector_tb;
	import meg_pkg::*;

	localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;
	localparam int unsigned ITEMS_PER_PHASE = 250;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	meg_in_if  in_ch();
	meg_out_if out_ch();

	modem_escape_guard_detector i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	guard_scoreboard sb;
	logic [31:0] now_ms;
	bit calm;
	int unsigned fed;

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Both transfers are sampled on the edge, before any driver update lands.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				sb.note_item({in_ch.mode, in_ch.data_byte, in_ch.time_ms});
			if (out_ch.valid && out_ch.ready)
				sb.check_result({out_ch.forward_valid, out_ch.forward_byte,
					out_ch.escape_done, out_ch.in_data_mode});
		end
	end

	initial begin
		out_ch.ready = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			int unsigned stall;
			stall = calm ? 0 : $urandom_range(5, 0);
			if (stall != 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	task automatic config_write(input logic reg_idx, input logic [7:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_idx, 2'b00};
		pwdata  <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (reg_idx == REG_ESCAPE_CHAR)
			sb.escape_char = value;
		else
			sb.guard_units = value;
		@(posedge clk);
	endtask

	task automatic send(input logic [MODE_W-1:0] mode, input logic [7:0] b,
			input int unsigned dt);
		int unsigned gap;
		now_ms = now_ms + dt;
		gap = calm ? 0 : $urandom_range(5, 0);
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.mode      <= mode;
		in_ch.data_byte <= b;
		in_ch.time_ms   <= now_ms;
		do @(posedge clk); while (!in_ch.ready);
		if (mode != MODE_RESERVED)
			fed++;
	endtask

	// Lets every outstanding result arrive so that the registers may be rewritten.
	task automatic drain();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.pending_link_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	function automatic int unsigned short_gap(input int unsigned g);
		return (g == 0) ? 0 : $urandom_range(g - 1, 0);
	endfunction

	function automatic int unsigned long_gap(input int unsigned g);
		if ($urandom_range(3, 0) == 0)
			return g;
		return g + $urandom_range(g / 2 + 3, 0);
	endfunction

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		b = 8'($urandom_range(255, 0));
		if (b == sb.escape_char)
			b = ~b;
		return b;
	endfunction

	// One attempt at a guarded escape, with random timing and occasional faults.
	task automatic escape_attempt();
		int unsigned g;
		int unsigned tail;
		g = sb.guard_ms();
		calm = ($urandom_range(3, 0) == 0);
		if (!sb.online || $urandom_range(4, 0) == 0)
			send(MODE_ENTER, 8'($urandom), $urandom_range(g + 20, 0));
		repeat ($urandom_range(3, 0))
			send(MODE_DATA, plain_byte(), $urandom_range(g + 50, 0));
		send(MODE_DATA, sb.escape_char,
			($urandom_range(6, 0) == 0) ? short_gap(g) : long_gap(g));
		repeat (2)
			send(MODE_DATA, sb.escape_char,
				($urandom_range(9, 0) == 0) ? long_gap(g) : short_gap(g));
		tail = $urandom_range(9, 0);
		if (tail == 0)
			send(MODE_DATA, sb.escape_char, short_gap(g));
		else if (tail == 1)
			send(MODE_DATA, plain_byte(), short_gap(g));
		repeat ($urandom_range(2, 0))
			send(MODE_TICK, 8'($urandom), short_gap(g) / 2);
		if ($urandom_range(9, 0) != 0)
			send(MODE_TICK, 8'($urandom), long_gap(g));
		if ($urandom_range(3, 0) == 0)
			send(MODE_DATA, 8'($urandom), $urandom_range(100, 0));
	endtask

	task automatic noise_burst();
		int unsigned g;
		int unsigned dt;
		logic [7:0] b;
		g = sb.guard_ms();
		repeat ($urandom_range(4, 1)) begin
			case ($urandom_range(3, 0))
				0: dt = 0;
				1: dt = short_gap(g);
				2: dt = long_gap(g);
				default: dt = $urandom;
			endcase
			b = ($urandom_range(2, 0) == 0) ? sb.escape_char : 8'($urandom);
			send(2'($urandom_range(3, 0)), b, dt);
		end
	endtask

	task automatic random_phase(input logic [7:0] esc, input logic [7:0] units,
			input logic [31:0] start_ms);
		int unsigned target;
		config_write(REG_ESCAPE_CHAR, esc);
		config_write(REG_GUARD_UNITS, units);
		now_ms = start_ms;
		target = fed + ITEMS_PER_PHASE;
		while (fed < target) begin
			if ($urandom_range(9, 0) < 8)
				escape_attempt();
			else
				noise_burst();
		end
		drain();
	endtask

	initial begin
		sb = new();
		arst_n          = 1'b0;
		calm            = 1'b0;
		fed             = 0;
		now_ms          = 32'd1000;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		in_ch.valid     = 1'b0;
		in_ch.mode      = MODE_DATA;
		in_ch.data_byte = '0;
		in_ch.time_ms   = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at reset settings: escape character '+', guard of 1000 ms.
		send(MODE_DATA, ESC_RESET_CHAR, 0);     // byte in command mode is dropped
		send(MODE_TICK, 8'h00, 5);              // tick in command mode
		send(MODE_RESERVED, 8'hFF, 5);          // reserved mode value
		send(MODE_ENTER, 8'h00, 5);
		send(MODE_ENTER, 8'h00, 10);            // enter again while online
		send(MODE_TICK, 8'h00, 3);              // nothing armed yet
		send(MODE_DATA, 8'h00, 5);
		send(MODE_DATA, ESC_RESET_CHAR, 100);   // escape without the silence before it
		send(MODE_DATA, ESC_RESET_CHAR, 1000);  // silence of exactly the guard
		send(MODE_DATA, ESC_RESET_CHAR, 999);
		send(MODE_DATA, ESC_RESET_CHAR, 1);     // third escape arms
		send(MODE_DATA, ESC_RESET_CHAR, 1);     // fourth one restarts the count, still armed
		send(MODE_TICK, 8'h00, 998);            // one short of the guard
		send(MODE_TICK, 8'h00, 1);              // guard reached, escape completes
		send(MODE_DATA, 8'hFF, 2);
		send(MODE_ENTER, 8'hFF, 5);
		send(MODE_DATA, ESC_RESET_CHAR, 1500);
		send(MODE_DATA, ESC_RESET_CHAR, 10);
		send(MODE_DATA, ESC_RESET_CHAR, 10);
		send(MODE_DATA, 8'hA5, 10);             // other byte disarms the escape
		send(MODE_TICK, 8'h00, 2000);
		send(MODE_RESERVED, 8'h00, 1);
		send(MODE_DATA, ESC_RESET_CHAR, 1200);
		send(MODE_DATA, ESC_RESET_CHAR, 1000);  // second escape too late
		drain();

		random_phase(8'hFF, 8'd0, $urandom);
		random_phase(8'h00, 8'd255, 32'hFFFF_FFFF - $urandom_range(20000, 0));
		random_phase(8'($urandom), 8'($urandom_range(8, 1)), $urandom);
		random_phase(8'($urandom), 8'($urandom), 32'hFFFF_FFFF - $urandom_range(3000, 0));
		random_phase(ESC_RESET_CHAR, GUARD_RESET_UNITS, $urandom);

		if (sb.pending_link_results.size() != 0)
			$display("%0t: %0d results never arrived", $time, sb.pending_link_results.size());
		if (sb.mismatches == 0 && sb.pending_link_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#400000;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/meg_pkg.sv
rtl/meg_if.sv
rtl/meg_cfg.sv
rtl/meg_engine.sv
rtl/modem_escape_guard_detector.sv
tb/modem_escape_guard_detector_tb.sv
